/* rtl/bcu_pkg.sv */
// Shared types for the binomial coefficient unit.
// Used by bcu_alu and binomial_coefficient_unit; no dependencies.
`default_nettype none
package bcu_pkg;

    typedef enum logic {
        OP_MUL,
        OP_DIV
    } t_alu_op;

    typedef struct packed {
        logic    start;
        t_alu_op op;
    } t_alu_req;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LIM,
        ST_WAIT,
        ST_LIM_CHK,
        ST_MUL_DONE,
        ST_DIV_DONE,
        ST_GCD,
        ST_GCD_STEP,
        ST_NR_DONE,
        ST_DR_DONE,
        ST_R2_DONE,
        ST_DR2_DONE,
        ST_LIM2_CHK,
        ST_MUL2_DONE,
        ST_NEXT,
        ST_OUT
    } t_state;

endpackage
`default_nettype wire

/* rtl/bcu_alu.sv */
// Shared bit-serial multiply / restoring divide unit, one bit per cycle.
// Depends on bcu_pkg. Product must fit in W bits (upper bits dropped).
`default_nettype none
module bcu_alu
    import bcu_pkg::*;
#(
    parameter int W = 64
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire t_alu_req     i_req,
    input  wire logic [W-1:0] i_a,
    input  wire logic [W-1:0] i_b,
    output logic              o_busy,
    output logic              o_done,
    output logic [W-1:0]      o_res,
    output logic [W-1:0]      o_rem
);
    localparam int CW = $clog2(W);

    logic [W-1:0]  r_x, n_x;     // accumulator or remainder
    logic [W-1:0]  r_q, n_q;     // multiplier or quotient
    logic [W-1:0]  r_b, n_b;     // multiplicand or divisor
    logic [CW-1:0] r_cnt, n_cnt;
    logic          r_busy, n_busy;
    t_alu_op       r_op, n_op;

    logic [W:0]    s_x, s_y;
    logic          s_sub;
    logic [W+1:0]  s_sum;
    logic          s_last;

    // the one shared adder/subtractor
    always_comb begin
        s_sub = (r_op == OP_DIV);
        if (s_sub) begin
            s_x = {r_x, r_q[W-1]};
            s_y = ~{1'b0, r_b};
        end else begin
            s_x = {1'b0, r_x};
            s_y = r_q[0] ? {1'b0, r_b} : '0;
        end
        s_sum = {1'b0, s_x} + {1'b0, s_y} + {{(W+1){1'b0}}, s_sub};
    end

    assign s_last = (r_cnt == CW'(W - 1));

    always_comb begin
        n_x    = r_x;
        n_q    = r_q;
        n_b    = r_b;
        n_cnt  = r_cnt;
        n_busy = r_busy;
        n_op   = r_op;
        if (i_req.start) begin
            n_op   = i_req.op;
            n_busy = 1'b1;
            n_cnt  = '0;
            n_x    = '0;
            if (i_req.op == OP_DIV) begin
                n_q = i_a;
                n_b = i_b;
            end else begin
                n_q = i_b;
                n_b = i_a;
            end
        end else if (r_busy) begin
            n_cnt = r_cnt + CW'(1);
            if (s_last) begin
                n_busy = 1'b0;
            end
            if (r_op == OP_DIV) begin
                // carry out set means the shifted remainder covers the divisor
                if (s_sum[W+1]) begin
                    n_x = s_sum[W-1:0];
                end else begin
                    n_x = s_x[W-1:0];
                end
                n_q = {r_q[W-2:0], s_sum[W+1]};
            end else begin
                n_x = s_sum[W-1:0];
                n_q = {1'b0, r_q[W-1:1]};
                n_b = {r_b[W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
            r_op   <= OP_DIV;
        end else begin
            r_busy <= n_busy;
            r_cnt  <= n_cnt;
            r_op   <= n_op;
        end
        r_x <= n_x;
        r_q <= n_q;
        r_b <= n_b;
    end

    assign o_busy = r_busy;
    assign o_done = r_busy && s_last;
    assign o_res  = (r_op == OP_DIV) ? r_q : r_x;
    assign o_rem  = r_x;

    a_no_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req.start |-> !r_busy)
        else $error("alu started while busy");
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && !i_req.start |=> !r_busy)
        else $error("alu busy after done");
    a_cnt_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_busy |-> !o_done)
        else $error("done without operation");

endmodule
`default_nettype wire

/* rtl/binomial_coefficient_unit.sv */
// Binomial coefficient C(n,k), multiplicative scheme with GCD cancellation.
// Depends on bcu_pkg and bcu_alu (shared serial multiply/divide unit).
//
//  channel | valid       | ready       | payload
//  input   | i_in_valid  | o_in_ready  | i_set_size, i_pick_count
//  output  | o_out_valid | i_out_ready | o_coefficient, o_overflowed
//
// Every multiply or divide runs on bcu_alu, one operation at a time. A loop
// step costs three operations (eight or more with GCD cancellation, one
// divide per Euclid step); shortcut cases bypass the unit.
// Reset is synchronous, active low, and clears the sequencer and output valid.
// Input is taken only in idle; a waiting result stalls only the final load.
`default_nettype none
module binomial_coefficient_unit
    import bcu_pkg::*;
#(
    parameter int WORD_BITS = 64
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic [63:0] i_set_size,
    input  wire logic [63:0] i_pick_count,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic [63:0]      o_coefficient,
    output logic             o_overflowed
);
    localparam int W = WORD_BITS;
    localparam logic [W-1:0] TOP = '1;

    t_state r_state, n_state;
    t_state r_after, n_after;

    logic [W-1:0] r_n, r_k, r_r, r_d, r_nr, r_dr, r_ga, r_gb, r_res;
    logic         r_phase, r_ovf;
    logic         r_out_valid, r_out_ovf;
    logic [W-1:0] r_out_coef;

    t_alu_req     s_req;
    logic [W-1:0] s_a, s_b;
    logic         alu_busy, alu_done;
    logic [W-1:0] alu_res, alu_rem;

    logic         s_acc, s_shortcut;
    logic [W-1:0] s_in_n, s_in_k, s_short_val;
    logic         s_out_free;

    assign s_in_n     = i_set_size[W-1:0];
    assign s_in_k     = i_pick_count[W-1:0];
    assign o_in_ready = (r_state == ST_IDLE);
    assign s_acc      = i_in_valid && o_in_ready;
    assign s_out_free = !r_out_valid || i_out_ready;

    always_comb begin
        s_shortcut  = 1'b1;
        s_short_val = '0;
        if (s_in_k > s_in_n) begin
            s_short_val = '0;
        end else if (s_in_k == '0 || s_in_k == s_in_n) begin
            s_short_val = W'(1);
        end else if (s_in_k == W'(1)) begin
            s_short_val = s_in_n;
        end else begin
            s_shortcut = 1'b0;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        n_after = r_after;
        case (r_state)
            ST_IDLE: begin
                if (s_acc) begin
                    n_state = s_shortcut ? ST_OUT : ST_LIM;
                end
            end
            ST_LIM: begin
                n_state = ST_WAIT;
                n_after = ST_LIM_CHK;
            end
            ST_WAIT: begin
                if (alu_done) begin
                    n_state = r_after;
                end
            end
            ST_LIM_CHK: begin
                if (r_r >= alu_res) begin
                    n_state = ST_GCD;
                end else begin
                    n_state = ST_WAIT;
                    n_after = ST_MUL_DONE;
                end
            end
            ST_MUL_DONE: begin
                n_state = ST_WAIT;
                n_after = ST_DIV_DONE;
            end
            ST_DIV_DONE: n_state = ST_NEXT;
            ST_GCD: begin
                n_state = ST_WAIT;
                if (r_gb != '0) begin
                    n_after = ST_GCD_STEP;
                end else if (!r_phase) begin
                    n_after = ST_NR_DONE;
                end else begin
                    n_after = ST_R2_DONE;
                end
            end
            ST_GCD_STEP: n_state = ST_GCD;
            ST_NR_DONE: begin
                n_state = ST_WAIT;
                n_after = ST_DR_DONE;
            end
            ST_DR_DONE: n_state = ST_GCD;
            ST_R2_DONE: begin
                n_state = ST_WAIT;
                n_after = ST_DR2_DONE;
            end
            ST_DR2_DONE: begin
                n_state = ST_WAIT;
                n_after = ST_LIM2_CHK;
            end
            ST_LIM2_CHK: begin
                if (r_r > alu_res) begin
                    n_state = ST_OUT;
                end else begin
                    n_state = ST_WAIT;
                    n_after = ST_MUL2_DONE;
                end
            end
            ST_MUL2_DONE: begin
                n_state = ST_WAIT;
                n_after = ST_DIV_DONE;
            end
            ST_NEXT: n_state = (r_d == r_k) ? ST_OUT : ST_LIM;
            ST_OUT: begin
                if (s_out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // requests to the shared unit
    always_comb begin
        s_req.start = 1'b0;
        s_req.op    = OP_DIV;
        s_a         = '0;
        s_b         = '0;
        case (r_state)
            ST_LIM: begin
                s_req.start = 1'b1;
                s_a         = TOP;
                s_b         = r_n;
            end
            ST_LIM_CHK: begin
                if (r_r < alu_res) begin
                    s_req.start = 1'b1;
                    s_req.op    = OP_MUL;
                    s_a         = r_r;
                    s_b         = r_n;
                end
            end
            ST_MUL_DONE: begin
                s_req.start = 1'b1;
                s_a         = alu_res;
                s_b         = r_d;
            end
            ST_GCD: begin
                s_req.start = 1'b1;
                if (r_gb != '0) begin
                    s_a = r_ga;
                    s_b = r_gb;
                end else if (!r_phase) begin
                    s_a = r_n;
                    s_b = r_ga;
                end else begin
                    s_a = r_r;
                    s_b = r_ga;
                end
            end
            ST_NR_DONE: begin
                s_req.start = 1'b1;
                s_a         = r_d;
                s_b         = r_ga;
            end
            ST_R2_DONE: begin
                s_req.start = 1'b1;
                s_a         = r_dr;
                s_b         = r_ga;
            end
            ST_DR2_DONE: begin
                s_req.start = 1'b1;
                s_a         = TOP;
                s_b         = r_nr;
            end
            ST_LIM2_CHK: begin
                if (r_r <= alu_res) begin
                    s_req.start = 1'b1;
                    s_req.op    = OP_MUL;
                    s_a         = r_r;
                    s_b         = r_nr;
                end
            end
            ST_MUL2_DONE: begin
                s_req.start = 1'b1;
                s_a         = alu_res;
                s_b         = r_dr;
            end
            default: s_req.start = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_after     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_after <= n_after;
            if (r_state == ST_OUT && s_out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end

        case (r_state)
            ST_IDLE: begin
                r_n   <= s_in_n;
                r_k   <= (s_in_k > (s_in_n >> 1)) ? s_in_n - s_in_k : s_in_k;
                r_r   <= W'(1);
                r_d   <= W'(1);
                r_res <= s_short_val;
                r_ovf <= 1'b0;
            end
            ST_LIM_CHK: begin
                r_ga    <= r_n;
                r_gb    <= r_d;
                r_phase <= 1'b0;
            end
            ST_DIV_DONE: r_r <= alu_res;
            ST_GCD_STEP: begin
                r_ga <= r_gb;
                r_gb <= alu_rem;
            end
            ST_NR_DONE: r_nr <= alu_res;
            ST_DR_DONE: begin
                r_dr    <= alu_res;
                r_ga    <= r_r;
                r_gb    <= alu_res;
                r_phase <= 1'b1;
            end
            ST_R2_DONE: r_r <= alu_res;
            ST_DR2_DONE: r_dr <= alu_res;
            ST_LIM2_CHK: begin
                // drop to zero when the reduced product cannot fit
                if (r_r > alu_res) begin
                    r_res <= '0;
                    r_ovf <= 1'b1;
                end
            end
            ST_NEXT: begin
                r_res <= r_r;
                r_n   <= r_n - W'(1);
                r_d   <= r_d + W'(1);
            end
            ST_OUT: begin
                if (s_out_free) begin
                    r_out_coef <= r_res;
                    r_out_ovf  <= r_ovf;
                end
            end
            default: ;
        endcase
    end

    bcu_alu #(.W(W)) u_alu (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (s_req),
        .i_a     (s_a),
        .i_b     (s_b),
        .o_busy  (alu_busy),
        .o_done  (alu_done),
        .o_res   (alu_res),
        .o_rem   (alu_rem)
    );

    assign o_out_valid   = r_out_valid;
    assign o_coefficient = 64'(r_out_coef);
    assign o_overflowed  = r_out_ovf;

    a_ovf_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_overflowed |-> o_coefficient == 64'd0)
        else $error("overflow with nonzero result");
    a_wait_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_WAIT |-> alu_busy)
        else $error("waiting on idle alu");
    a_acc_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_acc |=> !o_in_ready)
        else $error("ready right after transfer");

endmodule
`default_nettype wire

/* tb/tb_top.sv */
// Self-checking testbench for binomial_coefficient_unit: directed table, then random n/k.
// Depends on rtl/bcu_pkg.sv and rtl/binomial_coefficient_unit.sv; output checked by predictor.
`timescale 1ns / 100ps
`default_nettype none
module tb_top;

    typedef struct {
        logic [63:0] coef;
        logic        ovf;
    } t_choose;

    typedef struct {
        logic [63:0] n;
        logic [63:0] k;
        logic        typed;
        logic [63:0] coef;
        logic        ovf;
    } t_row;

    localparam logic [63:0] ALL_ONES = '1;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_ready;
    logic [63:0] i_set_size = '0;
    logic [63:0] i_pick_count = '0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    logic [63:0] o_coefficient;
    logic        o_overflowed;

    t_choose pending_q[$];
    int      error_cnt = 0;
    bit      calm = 1'b0;
    int      stall_left = 0;

    always #1 i_clk = ~i_clk;

    binomial_coefficient_unit dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_set_size   (i_set_size),
        .i_pick_count (i_pick_count),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_coefficient(o_coefficient),
        .o_overflowed (o_overflowed)
    );

    function automatic logic [63:0] gcd64(logic [63:0] a, logic [63:0] b);
        logic [63:0] t;
        while (b != 0) begin
            t = a % b;
            a = b;
            b = t;
        end
        return a;
    endfunction

    function automatic t_choose choose(logic [63:0] n, logic [63:0] k);
        t_choose     res;
        logic [63:0] r;
        logic [63:0] g;
        logic [63:0] nr;
        logic [63:0] dr;
        logic [63:0] d;
        r = 1;
        res.ovf = 1'b0;
        if (k > n) begin
            r = 0;
        end else if (k == 0 || k == n) begin
            r = 1;
        end else if (k == 1) begin
            r = n;
        end else begin
            if (k > n / 2) k = n - k;
            for (d = 1; d <= k; d++) begin
                if (r >= ALL_ONES / n) begin
                    // cancel common factors before the product can spill
                    g  = gcd64(n, d);
                    nr = n / g;
                    dr = d / g;
                    g  = gcd64(r, dr);
                    if (g == 0) g = 1;
                    r  = r / g;
                    dr = dr / g;
                    if (nr != 0 && r > ALL_ONES / nr) begin
                        r = 0;
                        res.ovf = 1'b1;
                        break;
                    end
                    r = r * nr;
                    if (dr != 0) r = r / dr;
                end else begin
                    r = (r * n) / d;
                end
                n--;
            end
        end
        res.coef = r;
        return res;
    endfunction

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        error_cnt++;
        $display("[%0t] mismatch %s: got %0h, want %0h", $realtime, what, got, want);
    endtask

    // result checker
    always @(posedge i_clk) begin
        t_choose exp_res;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_q.size() == 0) begin
                report_mismatch("unexpected transfer", o_coefficient, 64'd0);
            end else begin
                exp_res = pending_q.pop_front();
                if (o_coefficient !== exp_res.coef)
                    report_mismatch("coefficient", o_coefficient, exp_res.coef);
                if (o_overflowed !== exp_res.ovf)
                    report_mismatch("overflowed", 64'(o_overflowed), 64'(exp_res.ovf));
            end
        end
    end

    // receiver stalls in bursts
    always @(posedge i_clk) begin
        if (calm) begin
            stall_left <= 0;
            i_out_ready <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            i_out_ready <= 1'b0;
        end else if ($urandom_range(0, 5) != 0) begin
            i_out_ready <= 1'b1;
        end else begin
            stall_left <= $urandom_range(0, 13);
            i_out_ready <= 1'b0;
        end
    end

    task automatic send(logic [63:0] n, logic [63:0] k, t_choose want);
        int gap;
        if (!calm && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 14);
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_set_size   <= n;
        i_pick_count <= k;
        do @(posedge i_clk); while (!o_in_ready);
        pending_q.push_back(want);
    endtask

    task automatic send_predicted(logic [63:0] n, logic [63:0] k);
        send(n, k, choose(n, k));
    endtask

    task automatic drain();
        while (pending_q.size() != 0) @(posedge i_clk);
    endtask

    initial begin
        t_row        rows[$];
        t_choose     want;
        logic [63:0] n;
        logic [63:0] k;
        int          kind;
        rows = '{
            '{64'd0, 64'd0, 1'b1, 64'd1, 1'b0},
            '{64'd5, 64'd7, 1'b1, 64'd0, 1'b0},
            '{64'd0, ALL_ONES, 1'b1, 64'd0, 1'b0},
            '{ALL_ONES, ALL_ONES, 1'b1, 64'd1, 1'b0},
            '{ALL_ONES, 64'd0, 1'b1, 64'd1, 1'b0},
            '{ALL_ONES, 64'd1, 1'b1, ALL_ONES, 1'b0},
            '{64'd9, 64'd9, 1'b1, 64'd1, 1'b0},
            '{64'd9, 64'd1, 1'b1, 64'd9, 1'b0},
            '{64'd1, 64'd0, 1'b1, 64'd1, 1'b0},
            '{64'd10, 64'd5, 1'b0, 64'd0, 1'b0},
            '{64'd10, 64'd8, 1'b0, 64'd0, 1'b0},
            '{ALL_ONES, ALL_ONES - 1, 1'b0, 64'd0, 1'b0},
            '{ALL_ONES, 64'd2, 1'b0, 64'd0, 1'b0},
            '{64'h0000_0001_0000_0000, 64'd2, 1'b0, 64'd0, 1'b0},
            '{64'd62, 64'd31, 1'b0, 64'd0, 1'b0},
            '{64'd66, 64'd33, 1'b0, 64'd0, 1'b0},
            '{64'd67, 64'd33, 1'b0, 64'd0, 1'b0},
            '{64'd68, 64'd34, 1'b0, 64'd0, 1'b0},
            '{64'd100, 64'd50, 1'b0, 64'd0, 1'b0},
            '{64'h8000_0000_0000_0000, 64'h4000_0000_0000_0000, 1'b0, 64'd0, 1'b0},
            '{64'd1000000, 64'd4, 1'b0, 64'd0, 1'b0},
            '{64'd4, 64'd2, 1'b0, 64'd0, 1'b0}
        };

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (rows[i]) begin
            if (rows[i].typed) begin
                want.coef = rows[i].coef;
                want.ovf  = rows[i].ovf;
                send(rows[i].n, rows[i].k, want);
            end else begin
                send_predicted(rows[i].n, rows[i].k);
            end
        end

        for (int i = 0; i < 118; i++) begin
            if (i == 50) begin
                // hold off until the unit has emptied
                i_in_valid <= 1'b0;
                @(posedge i_clk);
                drain();
            end
            if (i == 98) calm = 1'b1;
            kind = $urandom_range(0, 9);
            case (kind)
                0: begin
                    n = {$urandom, $urandom};
                    k = {$urandom, $urandom};
                end
                1: begin
                    n = {$urandom, $urandom};
                    k = n + {$urandom, $urandom_range(1, 32'hFFFF_FFFF)};
                    if (k <= n) k = ALL_ONES;
                    if (n == ALL_ONES) n = n - 1;
                end
                2: begin
                    n = {$urandom, $urandom};
                    k = 64'($urandom_range(2, 8));
                    if ($urandom_range(0, 1) == 1) k = n - k;
                end
                3: begin
                    n = {32'd0, $urandom};
                    k = 64'($urandom_range(2, 5));
                end
                4: begin
                    n = {$urandom, $urandom};
                    case ($urandom_range(0, 3))
                        0: k = 0;
                        1: k = 1;
                        2: k = n;
                        default: k = n - 1;
                    endcase
                end
                default: begin
                    n = 64'($urandom_range(0, 80));
                    k = 64'($urandom_range(0, 82));
                end
            endcase
            send_predicted(n, k);
        end

        i_in_valid <= 1'b0;
        drain();
        repeat (50) @(posedge i_clk);
        if (error_cnt == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    initial begin
        #400_000_000;
        $display("FAILURE");
        $finish;
    end

endmodule
`default_nettype wire
